[sv/r2h_pkg.sv]
package r2h_pkg;

  // quotient bits developed by the cell row, one bit per cell
  localparam int QBITS = 8;

  // hue sector codes, named after the channel that holds the maximum
  localparam logic [1:0] SECT_RED   = 2'd0;
  localparam logic [1:0] SECT_GREEN = 2'd1;
  localparam logic [1:0] SECT_BLUE  = 2'd2;

  localparam logic [8:0] HUE_GREEN = 9'd120;
  localparam logic [8:0] HUE_BLUE  = 9'd240;
  localparam logic [8:0] HUE_WRAP  = 9'd360;

  // one restoring-division lane: partial remainder, numerator bits still
  // to shift in, quotient bits found so far
  typedef struct packed {
    logic [7:0] rem;
    logic [7:0] low;
    logic [7:0] quo;
  } div_lane_t;

  // everything a pixel carries from one cell to the next
  typedef struct packed {
    logic       vld;
    div_lane_t  sat;    // divisor is hi
    div_lane_t  hue;    // divisor is span
    logic [7:0] hi;
    logic [7:0] span;
    logic [1:0] sect;
    logic       neg;    // hue difference was negative
  } stage_t;

endpackage

[sv/r2h_div_cell.sv]
module r2h_div_cell
  import r2h_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   adv,
  input  stage_t din,
  output stage_t dout
);

  stage_t nxt;

  function automatic div_lane_t div_step(input div_lane_t ln, input logic [7:0] dvs);
    logic [8:0] trial;
    logic       ge;
    div_lane_t  res;
    trial   = {ln.rem, ln.low[7]};
    ge      = (trial >= {1'b0, dvs});
    res.rem = ge ? 8'(trial - {1'b0, dvs}) : trial[7:0];
    res.low = {ln.low[6:0], 1'b0};
    res.quo = {ln.quo[6:0], ge};
    return res;
  endfunction

  always_comb begin
    nxt     = din;
    nxt.sat = div_step(din.sat, din.hi);
    nxt.hue = div_step(din.hue, din.span);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.vld <= 1'b0;
    end else if (adv) begin
      dout <= nxt;
    end
  end

endmodule

[sv/rgb_to_hsv_converter.sv]
// RGB to HSV pixel converter. One pixel enters per clock and one result
// leaves per clock while the sink keeps taking results. The path runs
// through one front stage (max, min, span, scaled numerators) captured at
// the input transaction, a row of eight division cells that each settle one
// quotient bit for saturation and hue together, and one finishing stage that
// adds the sector offset and wraps negative hues into the output register.
// The eight-cell quotient chain sets the latency. A two-entry output
// (register plus skid) keeps taking pixels while one result waits.
// Brightness is the channel maximum, saturation is 255*(max-min)/max
// truncated, hue is in whole degrees 0..359, and grey or black pixels give
// hue 0 and saturation 0. Ties for the maximum go to red, then green.
module rgb_to_hsv_converter
  import r2h_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // red[7:0], green[15:8], blue[23:16]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // hue[8:0], saturation[16:9], brightness[24:17], zero
);

  logic [7:0] red, green, blue;
  assign red   = s_axis_tdata[7:0];
  assign green = s_axis_tdata[15:8];
  assign blue  = s_axis_tdata[23:16];

  // pipeline moves whenever the skid slot is free
  logic skid_valid;
  logic adv;
  assign adv           = !skid_valid;
  assign s_axis_tready = adv;

  // front stage: extremes, sector and scaled numerators
  logic [7:0]  hi, lo, span, mag;
  logic [1:0]  sect;
  logic signed [8:0] diff;
  logic [15:0] hnum, snum;
  stage_t      front;

  always_comb begin
    hi = red;
    if (green > hi) hi = green;
    if (blue > hi) hi = blue;
    lo = red;
    if (green < lo) lo = green;
    if (blue < lo) lo = blue;
    span = hi - lo;

    // tie order: red, then green, then blue
    if (hi == red) begin
      sect = SECT_RED;
      diff = $signed({1'b0, green}) - $signed({1'b0, blue});
    end else if (hi == green) begin
      sect = SECT_GREEN;
      diff = $signed({1'b0, blue}) - $signed({1'b0, red});
    end else begin
      sect = SECT_BLUE;
      diff = $signed({1'b0, red}) - $signed({1'b0, green});
    end
    mag = diff[8] ? 8'(-diff) : diff[7:0];

    // 60*mag and 255*span by shift and subtract
    hnum = ({8'd0, mag} << 6) - ({8'd0, mag} << 2);
    snum = ({span, 8'd0}) - {8'd0, span};

    front.vld     = s_axis_tvalid;
    // upper numerator byte starts below the divisor, so eight bits suffice
    front.sat.rem = snum[15:8];
    front.sat.low = snum[7:0];
    front.sat.quo = 8'd0;
    front.hue.rem = hnum[15:8];
    front.hue.low = hnum[7:0];
    front.hue.quo = 8'd0;
    front.hi      = hi;
    front.span    = span;
    front.sect    = sect;
    front.neg     = diff[8];
  end

  stage_t head;
  stage_t stg [0:QBITS];

  always_ff @(posedge clk) begin
    if (rst) begin
      head.vld <= 1'b0;
    end else if (adv) begin
      head <= front;
    end
  end

  assign stg[0] = head;

  // row of division cells, one quotient bit each
  for (genvar k = 0; k < QBITS; k++) begin : g_cell
    r2h_div_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .adv  (adv),
      .din  (stg[k]),
      .dout (stg[k+1])
    );
  end

  // finishing: sector offset, sign, wrap, grey and black overrides
  stage_t     last;
  logic [8:0] q, hue_c;
  logic [7:0] sat_c;
  logic [31:0] res_data;

  always_comb begin
    last = stg[QBITS];
    q    = {1'b0, last.hue.quo};
    case (last.sect)
      // a negative difference that truncates to zero stays at zero
      SECT_RED:   hue_c = (last.neg && q != 9'd0) ? HUE_WRAP - q : q;
      SECT_GREEN: hue_c = last.neg ? HUE_GREEN - q : HUE_GREEN + q;
      SECT_BLUE:  hue_c = last.neg ? HUE_BLUE - q : HUE_BLUE + q;
      default:    hue_c = 9'd0;
    endcase
    if (last.span == 8'd0) hue_c = 9'd0;
    sat_c = (last.hi == 8'd0) ? 8'd0 : last.sat.quo;
    res_data = {7'd0, last.hi, sat_c, hue_c};
  end

  // output register with one skid entry behind it
  logic [31:0] out_data, skid_data;
  logic        out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (skid_valid) begin
        if (m_axis_tready) begin
          out_data   <= skid_data;
          skid_valid <= 1'b0;
        end
      end else if (last.vld) begin
        if (!out_valid || m_axis_tready) begin
          out_data  <= res_data;
          out_valid <= 1'b1;
        end else begin
          skid_data  <= res_data;
          skid_valid <= 1'b1;
        end
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  // a filled skid entry always has a result in front of it
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> m_axis_tvalid)
    else $error("skid entry held with empty output register");

  // skid entry is kept until the output transaction completes
  a_skid_holds: assert property (@(posedge clk) disable iff (rst)
    skid_valid && !m_axis_tready |=> skid_valid)
    else $error("skid entry dropped while output stalled");

  // hue stays inside one turn
  a_hue_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[8:0] < HUE_WRAP)
    else $error("hue out of range");

  // black pixel carries no hue and no saturation
  a_black: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[24:17] == 8'd0
      |-> m_axis_tdata[16:0] == 17'd0)
    else $error("black pixel with nonzero hue or saturation");

endmodule

[tb/hsv_pixel_checker.sv]
`timescale 1ns / 100ps

// watches both stream channels, predicts hsv for every accepted pixel and
// compares each accepted result with the oldest prediction
module hsv_pixel_checker
  import r2h_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // red[7:0], green[15:8], blue[23:16]
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [31:0] m_axis_tdata,   // hue[8:0], saturation[16:9], brightness[24:17], zero
  output int          mismatch_count,
  output int          hsv_in_flight
);

  typedef struct packed {
    logic [8:0] hue;
    logic [7:0] sat;
    logic [7:0] val;
  } hsv_t;

  hsv_t pending_hsv[$];

  function automatic hsv_t hsv_of_pixel(input logic [23:0] pix);
    int         r;
    int         g;
    int         b;
    int         hi;
    int         lo;
    int         span;
    int         h;
    int         s;
    logic [1:0] sect;
    hsv_t       res;
    r = int'(pix[7:0]);
    g = int'(pix[15:8]);
    b = int'(pix[23:16]);
    // ties go to red, then green
    hi = r;
    sect = SECT_RED;
    if (g > hi) begin
      hi = g;
      sect = SECT_GREEN;
    end
    if (b > hi) begin
      hi = b;
      sect = SECT_BLUE;
    end
    lo = r;
    if (g < lo) lo = g;
    if (b < lo) lo = b;
    span = hi - lo;
    s = (hi != 0) ? (255 * span) / hi : 0;
    h = 0;
    if (span != 0) begin
      case (sect)
        SECT_RED:   h = (60 * (g - b)) / span;
        SECT_GREEN: h = (60 * (b - r)) / span + int'(HUE_GREEN);
        default:    h = (60 * (r - g)) / span + int'(HUE_BLUE);
      endcase
      if (h < 0) h = h + int'(HUE_WRAP);
    end
    res.hue = h[8:0];
    res.sat = s[7:0];
    res.val = hi[7:0];
    return res;
  endfunction

  always @(posedge clk) begin
    hsv_t want;
    int   errs;
    errs = 0;
    if (rst) begin
      pending_hsv.delete();
      mismatch_count <= 0;
      hsv_in_flight <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_hsv.size() == 0) begin
          $error("result transaction with no pixel waiting: data %h", m_axis_tdata);
          errs = errs + 1;
        end else begin
          want = pending_hsv.pop_front();
          if (m_axis_tdata[8:0] !== want.hue) begin
            $error("hue mismatch: expected %0d, actual %0d", want.hue, m_axis_tdata[8:0]);
            errs = errs + 1;
          end
          if (m_axis_tdata[16:9] !== want.sat) begin
            $error("saturation mismatch: expected %0d, actual %0d",
                   want.sat, m_axis_tdata[16:9]);
            errs = errs + 1;
          end
          if (m_axis_tdata[24:17] !== want.val) begin
            $error("brightness mismatch: expected %0d, actual %0d",
                   want.val, m_axis_tdata[24:17]);
            errs = errs + 1;
          end
          if (m_axis_tdata[31:25] !== 7'd0) begin
            $error("padding mismatch: expected 0, actual %0d", m_axis_tdata[31:25]);
            errs = errs + 1;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) pending_hsv.push_back(hsv_of_pixel(s_axis_tdata));
      mismatch_count <= mismatch_count + errs;
      hsv_in_flight <= pending_hsv.size();
    end
  end

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps

module testbench;

  localparam int CYCLE_LIMIT = 200000;  // far above the slowest legal run
  localparam int RANDOM_PIXELS = 1000;
  localparam int DRAIN_CYCLES = 24;     // pipeline is ten deep, plus skid

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;     // red[7:0], green[15:8], blue[23:16]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;          // hue[8:0], saturation[16:9], brightness[24:17], zero

  int mismatch_count;
  int hsv_in_flight;
  int cycle_count = 0;

  // idling switches, flipped by the stimulus phases
  bit source_gaps = 1'b1;
  bit sink_stalls = 1'b1;

  // 20 ns period
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  rgb_to_hsv_converter u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  hsv_pixel_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .s_axis_tvalid  (s_axis_tvalid),
    .s_axis_tready  (s_axis_tready),
    .s_axis_tdata   (s_axis_tdata),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .m_axis_tdata   (m_axis_tdata),
    .mismatch_count (mismatch_count),
    .hsv_in_flight  (hsv_in_flight)
  );

  // result side back-pressure, about a third of the cycles when enabled
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= !(sink_stalls && ($urandom_range(0, 99) < 34));
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // offer one pixel and hold it until the transaction completes; tready is
  // read at the falling edge, where it already holds its value for the
  // next rising edge
  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    bit taken;
    while (source_gaps && ($urandom_range(0, 99) < 34)) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {b, g, r};
    do begin
      @(negedge clk);
      taken = s_axis_tready;
      @(posedge clk);
    end while (!taken);
  endtask

  // wait until every predicted result has been taken
  task automatic wait_drained();
    do @(posedge clk); while (hsv_in_flight != 0);
  endtask

  function automatic logic [7:0] clamp_channel(input int v);
    if (v < 0) return 8'd0;
    if (v > 255) return 8'd255;
    return v[7:0];
  endfunction

  // mostly uniform pixels, plus near-grey ones, tied maxima and pixels
  // with channels pinned at the rails
  task automatic send_random_pixel();
    int         base;
    logic [7:0] tie;
    logic [7:0] other;
    case ($urandom_range(0, 9))
      6, 7: begin
        base = $urandom_range(0, 255);
        send_pixel(clamp_channel(base + $urandom_range(0, 6) - 3),
                   clamp_channel(base + $urandom_range(0, 6) - 3),
                   clamp_channel(base + $urandom_range(0, 6) - 3));
      end
      8: begin
        tie = 8'($urandom_range(0, 255));
        other = 8'($urandom_range(0, 255));
        case ($urandom_range(0, 2))
          0:       send_pixel(tie, tie, other);
          1:       send_pixel(tie, other, tie);
          default: send_pixel(other, tie, tie);
        endcase
      end
      9: begin
        send_pixel($urandom_range(0, 1) ? 8'hff : 8'h00,
                   $urandom_range(0, 1) ? 8'hff : 8'(($urandom_range(0, 255))),
                   $urandom_range(0, 1) ? 8'h00 : 8'(($urandom_range(0, 255))));
      end
      default: begin
        send_pixel(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)));
      end
    endcase
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: grey, black, pure primaries, ties and wrapped hues
    send_pixel(8'd0, 8'd0, 8'd0);       // black, zero divisor
    send_pixel(8'd255, 8'd255, 8'd255); // white
    send_pixel(8'd128, 8'd128, 8'd128); // mid grey
    send_pixel(8'd1, 8'd1, 8'd1);
    send_pixel(8'd255, 8'd0, 8'd0);     // pure red
    send_pixel(8'd0, 8'd255, 8'd0);     // pure green
    send_pixel(8'd0, 8'd0, 8'd255);     // pure blue
    send_pixel(8'd255, 8'd255, 8'd0);   // red and green tie, red wins
    send_pixel(8'd255, 8'd0, 8'd255);   // red and blue tie, red wins
    send_pixel(8'd0, 8'd255, 8'd255);   // green and blue tie, green wins
    send_pixel(8'd255, 8'd0, 8'd1);     // negative difference, hue truncates to zero
    send_pixel(8'd255, 8'd0, 8'd254);
    send_pixel(8'd100, 8'd0, 8'd1);     // negative hue that truncates to zero
    send_pixel(8'd1, 8'd0, 8'd0);       // smallest nonzero span
    send_pixel(8'd0, 8'd1, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd1);
    send_pixel(8'd255, 8'd254, 8'd254); // tiny saturation
    send_pixel(8'd254, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd254, 8'd255);
    send_pixel(8'd170, 8'd85, 8'd0);
    send_pixel(8'd12, 8'd200, 8'd100);
    send_pixel(8'd200, 8'd100, 8'd230);

    for (int i = 0; i < RANDOM_PIXELS; i++) begin
      if (i == 300) begin
        // let the whole pipeline empty before sending on
        s_axis_tvalid <= 1'b0;
        wait_drained();
      end
      if (i == 400) begin
        // long stretch at full rate on both sides
        source_gaps = 1'b0;
        sink_stalls = 1'b0;
      end
      if (i == 700) begin
        source_gaps = 1'b1;
        sink_stalls = 1'b1;
      end
      send_random_pixel();
    end
    s_axis_tvalid <= 1'b0;

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
